>>> rtl/core/ptsc_pkg.sv
// Shared types and constants for the PPS time sync calibrator.
// Holds the request and result payload structs, event codes, register map and divider constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptsc_pkg;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] ms_tick;
    logic [63:0] us_counter;
    logic [31:0] utc_seconds;
  } in_item_t;

  typedef struct packed {
    logic        time_valid;
    logic [31:0] seconds;
    logic [19:0] microseconds;
    logic [31:0] delay_ms;
    logic [1:0]  sync_phase;
    logic        calibrated;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_MEASURE  = 2'd1,
    PH_WAIT_UTC = 2'd2
  } phase_t;

  // event codes carried in the mode field
  localparam logic [2:0] MODE_PPS   = 3'd0;
  localparam logic [2:0] MODE_MSG   = 3'd1;
  localparam logic [2:0] MODE_UTC   = 3'd2;
  localparam logic [2:0] MODE_CHECK = 3'd3;
  localparam logic [2:0] MODE_QUERY = 3'd4;

  // register map, selected by paddr[2]
  localparam logic REG_STABLE = 1'b0;
  localparam logic REG_RECAL  = 1'b1;

  localparam logic [7:0]  STABLE_RST = 8'd4;
  localparam logic [31:0] RECAL_RST  = 32'd60000;

  localparam logic [8:0]  PULSE_MAX = 9'd511;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // 1e6 = 64 * 15625; the odd factor is divided 16 bits at a time
  localparam logic [29:0] DIV_ODD   = 30'd15625;
  localparam logic [30:0] DIV_RECIP = 31'd1125899906; // floor(2^44 / 15625)

endpackage : ptsc_pkg

`default_nettype wire

>>> rtl/core/pps_time_sync_calibrator_top.sv
// PPS time sync calibrator: usage
// Channels: in_valid/in_ready carry one event request (in_item: mode, ms_tick,
// us_counter, utc_seconds); out_valid/out_ready return one status result per
// request (out_item). APB-style port: stable_pulses at 0x0, recalib_interval_ms
// at 0x4, no wait states; write only while no request is in flight.
// Flow: one request is taken per cycle while in_ready is high; the calibration
// state is updated in the accept cycle, and a query's elapsed microseconds are
// split into seconds and sub-second part by a nine-stage constant divider (four
// 16-bit digit steps, each one multiply stage and one correction stage, then the
// epoch add) that follows the input register.
// Stall: when out_ready is low the output holds; earlier stages keep accepting
// until their slots fill, then in_ready drops.
// Reset (rst_n low, synchronous): pipeline emptied, calibration state cleared,
// registers back to 4 pulses and 60000 ms.
// Depends on ptsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pps_time_sync_calibrator_top (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  ptsc_pkg::in_item_t      in_item,
  output logic                    out_valid,
  input  wire                     out_ready,
  output ptsc_pkg::out_item_t     out_item,
  input  wire                     psel,
  input  wire                     penable,
  input  wire                     pwrite,
  input  wire  [2:0]              paddr,
  input  wire  [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import ptsc_pkg::*;

  localparam int NSTG = 10;

  typedef struct packed {
    logic        time_valid;
    logic [31:0] delay_ms;
    logic [1:0]  sync_phase;
    logic        calibrated;
    logic        qry;
    logic [31:0] epoch;
    logic [63:0] elapsed;
    logic [29:0] dvd;
    logic [15:0] q_est;
    logic [13:0] rem;
    logic [31:0] q_acc;
  } stage_t;

  // configuration
  logic [7:0]  stable_r;
  logic [31:0] recal_r;
  logic        wr_en;

  // calibration state
  phase_t      phase_r,       phase_nxt;
  logic [8:0]  pulse_cnt_r,   pulse_cnt_nxt;
  logic [31:0] pulse_ms_r,    pulse_ms_nxt;
  logic [31:0] delay_r,       delay_nxt;
  logic [31:0] calib_tick_r,  calib_tick_nxt;
  logic [31:0] calib_cnt_r,   calib_cnt_nxt;
  logic [31:0] target_r,      target_nxt;
  logic [31:0] prev_r,        prev_nxt;
  logic        calib_flag_r,  calib_flag_nxt;
  logic [63:0] us_base_r,     us_base_nxt;

  // pipeline
  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   go;
  stage_t          stg_in;
  stage_t          stg_r   [NSTG];
  stage_t          stg_nxt [NSTG];
  logic            in_fire;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_STABLE: prdata = {24'd0, stable_r};
      REG_RECAL:  prdata = recal_r;
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= STABLE_RST;
      recal_r  <= RECAL_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_STABLE: stable_r <= pwdata[7:0];
        REG_RECAL:  recal_r  <= pwdata;
        default:    ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  always_comb begin
    go[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      go[k] = !vld_r[k] || go[k+1];
    end
  end

  assign in_ready  = go[0];
  assign in_fire   = in_valid & go[0];
  assign out_valid = vld_r[NSTG-1];

  // ---------------- event update ----------------
  always_comb begin
    phase_nxt      = phase_r;
    pulse_cnt_nxt  = pulse_cnt_r;
    pulse_ms_nxt   = pulse_ms_r;
    delay_nxt      = delay_r;
    calib_tick_nxt = calib_tick_r;
    calib_cnt_nxt  = calib_cnt_r;
    target_nxt     = target_r;
    prev_nxt       = prev_r;
    calib_flag_nxt = calib_flag_r;
    us_base_nxt    = us_base_r;

    case (in_item.mode)
      MODE_PPS: begin
        // latch a freshly armed target on this pulse
        if (!calib_flag_r && (prev_r != target_r)) begin
          us_base_nxt    = in_item.us_counter;
          calib_tick_nxt = in_item.ms_tick;
          prev_nxt       = target_r;
          calib_flag_nxt = 1'b1;
          if (calib_cnt_r != COUNT_MAX) begin
            calib_cnt_nxt = calib_cnt_r + 32'd1;
          end
        end
        if (pulse_cnt_r < PULSE_MAX) begin
          pulse_cnt_nxt = pulse_cnt_r + 9'd1;
        end
        if (pulse_cnt_nxt > {1'b0, stable_r}) begin
          pulse_ms_nxt = in_item.ms_tick;
          if (phase_r == PH_IDLE) begin
            phase_nxt = PH_MEASURE;
          end
        end
      end
      MODE_MSG: begin
        if (phase_r == PH_MEASURE) begin
          delay_nxt = in_item.ms_tick - pulse_ms_r;
          phase_nxt = calib_flag_r ? PH_IDLE : PH_WAIT_UTC;
        end
      end
      MODE_UTC: begin
        if ((phase_r == PH_WAIT_UTC) && !calib_flag_r) begin
          phase_nxt  = PH_IDLE;
          prev_nxt   = target_r;
          target_nxt = in_item.utc_seconds + 32'd1;
        end
      end
      MODE_CHECK: begin
        // drop an aged calibration so a newly armed target can renew it on a later pulse
        if ((calib_tick_r != 32'd0) &&
            ((in_item.ms_tick - calib_tick_r) >= recal_r)) begin
          calib_tick_nxt = 32'd0;
          calib_flag_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    stg_in.time_valid = (calib_cnt_nxt != 32'd0);
    stg_in.delay_ms   = delay_nxt;
    stg_in.sync_phase = phase_nxt;
    stg_in.calibrated = calib_flag_nxt;
    stg_in.qry        = (in_item.mode == MODE_QUERY) && (calib_cnt_r != 32'd0);
    stg_in.epoch      = calib_flag_r ? target_r : prev_r;
    stg_in.elapsed    = in_item.us_counter - us_base_r;
    stg_in.dvd        = 30'd0;
    stg_in.q_est      = 16'd0;
    stg_in.rem        = 14'd0;
    stg_in.q_acc      = 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      pulse_cnt_r  <= 9'd0;
      pulse_ms_r   <= 32'd0;
      delay_r      <= 32'd0;
      calib_tick_r <= 32'd0;
      calib_cnt_r  <= 32'd0;
      target_r     <= 32'd0;
      prev_r       <= 32'd0;
      calib_flag_r <= 1'b0;
      us_base_r    <= 64'd0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      pulse_cnt_r  <= pulse_cnt_nxt;
      pulse_ms_r   <= pulse_ms_nxt;
      delay_r      <= delay_nxt;
      calib_tick_r <= calib_tick_nxt;
      calib_cnt_r  <= calib_cnt_nxt;
      target_r     <= target_nxt;
      prev_r       <= prev_nxt;
      calib_flag_r <= calib_flag_nxt;
      us_base_r    <= us_base_nxt;
    end
  end

  // ---------------- divider stages ----------------
  // odd stages estimate one quotient digit by reciprocal multiply, even stages
  // correct it and carry the remainder, the last stage adds the epoch
  always_comb begin
    logic [63:0] ep;
    logic [29:0] dvd;
    logic [60:0] prod;
    logic [29:0] qd;
    logic [29:0] r_est;
    logic [29:0] r_fix;
    logic [15:0] qc;
    ep    = 64'd0;
    dvd   = 30'd0;
    prod  = 61'd0;
    qd    = 30'd0;
    r_est = 30'd0;
    r_fix = 30'd0;
    qc    = 16'd0;
    stg_nxt[0] = stg_in;
    for (int k = 1; k < NSTG; k++) begin
      stg_nxt[k] = stg_r[k-1];
      if (k == NSTG - 1) begin
        if (stg_r[k-1].qry) begin
          stg_nxt[k].q_acc = stg_r[k-1].q_acc + stg_r[k-1].epoch;
        end else begin
          stg_nxt[k].q_acc   = 32'd0;
          stg_nxt[k].rem     = 14'd0;
          stg_nxt[k].elapsed = 64'd0;
        end
      end else if (k[0]) begin
        ep   = {6'd0, stg_r[k-1].elapsed[63:6]};
        dvd  = {stg_r[k-1].rem, ep[63-16*(k>>1) -: 16]};
        prod = 61'(dvd) * 61'(DIV_RECIP);
        stg_nxt[k].dvd   = dvd;
        stg_nxt[k].q_est = prod[59:44];
      end else begin
        qd    = 30'(stg_r[k-1].q_est) * DIV_ODD;
        r_est = stg_r[k-1].dvd - qd;
        // estimate is low by at most one
        if (r_est >= DIV_ODD) begin
          r_fix = r_est - DIV_ODD;
          qc    = stg_r[k-1].q_est + 16'd1;
        end else begin
          r_fix = r_est;
          qc    = stg_r[k-1].q_est;
        end
        stg_nxt[k].rem   = r_fix[13:0];
        stg_nxt[k].q_acc = {stg_r[k-1].q_acc[15:0], qc};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (go[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (go[0]) begin
        vld_r[0] <= in_fire;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (go[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // ---------------- result ----------------
  always_comb begin
    out_item.time_valid   = stg_r[NSTG-1].time_valid;
    out_item.seconds      = stg_r[NSTG-1].q_acc;
    out_item.microseconds = {stg_r[NSTG-1].rem, stg_r[NSTG-1].elapsed[5:0]};
    out_item.delay_ms     = stg_r[NSTG-1].delay_ms;
    out_item.sync_phase   = stg_r[NSTG-1].sync_phase;
    out_item.calibrated   = stg_r[NSTG-1].calibrated;
  end

endmodule : pps_time_sync_calibrator_top

`default_nettype wire

>>> tb/tb_pps_time_sync_calibrator_top.sv
// Testbench for pps_time_sync_calibrator_top: a directed event table, then random
// pulse/message/UTC/check/query sequences, checked against an in-bench calibration model.
// Depends on ptsc_pkg and the RTL top module.
`timescale 1ns / 1ps

module tb_pps_time_sync_calibrator_top;
  import ptsc_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int DRAIN_CYCLES    = 16;
  localparam int ITEMS_PER_PHASE = 290;

  localparam logic [63:0] US_PER_SEC = 64'd1000000;
  localparam logic [31:0] ALL32      = 32'hFFFF_FFFF;
  localparam logic [63:0] ALL64      = 64'hFFFF_FFFF_FFFF_FFFF;

  // mode values the block does not decode
  localparam logic [2:0] MODE_RSVD_A = 3'd5;
  localparam logic [2:0] MODE_RSVD_B = 3'd6;
  localparam logic [2:0] MODE_RSVD_C = 3'd7;

  localparam out_item_t STATUS_CLEAR = '0;

  typedef enum int {IDLE_LIGHT_SEND, IDLE_HEAVY_SEND, IDLE_NONE} idle_mode_t;

  typedef struct {
    in_item_t ev;
    bit       clear_status;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pps_time_sync_calibrator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #4 clk = ~clk;

  // calibration model state and register mirror
  logic [7:0]  cfg_stable = STABLE_RST;
  logic [31:0] cfg_interval = RECAL_RST;
  phase_t      sync_state = PH_IDLE;
  logic [8:0]  pulse_cnt = '0;
  logic [31:0] pulse_tick = '0;
  logic [31:0] delay_last = '0;
  logic [31:0] cal_tick = '0;
  logic [31:0] cal_cnt = '0;
  logic [31:0] epoch_target = '0;
  logic [31:0] epoch_prev = '0;
  logic        cal_on = 1'b0;
  logic [63:0] base_us = '0;

  out_item_t   status_q[$];
  out_item_t   status_now;
  bit          in_typed = 1'b0;
  idle_mode_t  idle_sel = IDLE_NONE;
  int          fail_cnt = 0;
  int          quiet_cycles = 0;
  int          events_sent = 0;
  dir_row_t    dir_rows[$];

  // local view of time for the random sequences
  logic [31:0] tick_now;
  logic [63:0] usc_now;
  logic [31:0] utc_now;

  function automatic out_item_t step_calibration(input in_item_t ev);
    out_item_t   r;
    logic [31:0] age;
    logic [63:0] elapsed;
    logic [63:0] whole_s;
    logic [63:0] frac_us;
    r = '0;
    case (ev.mode)
      MODE_PPS: begin
        if (!cal_on && epoch_prev != epoch_target) begin
          base_us    = ev.us_counter;
          cal_tick   = ev.ms_tick;
          epoch_prev = epoch_target;
          cal_on     = 1'b1;
          if (cal_cnt != COUNT_MAX) cal_cnt = cal_cnt + 32'd1;
        end
        if (pulse_cnt < PULSE_MAX) pulse_cnt = pulse_cnt + 9'd1;
        if (pulse_cnt > {1'b0, cfg_stable}) begin
          pulse_tick = ev.ms_tick;
          if (sync_state == PH_IDLE) sync_state = PH_MEASURE;
        end
      end
      MODE_MSG: begin
        if (sync_state == PH_MEASURE) begin
          delay_last = ev.ms_tick - pulse_tick;
          sync_state = cal_on ? PH_IDLE : PH_WAIT_UTC;
        end
      end
      MODE_UTC: begin
        if (sync_state == PH_WAIT_UTC && !cal_on) begin
          sync_state   = PH_IDLE;
          epoch_prev   = epoch_target;
          epoch_target = ev.utc_seconds + 32'd1;
        end
      end
      MODE_CHECK: begin
        age = ev.ms_tick - cal_tick;
        // a zero calibration tick means nothing to expire
        if (cal_tick != 32'd0 && age >= cfg_interval) begin
          cal_tick = '0;
          cal_on   = 1'b0;
        end
      end
      MODE_QUERY: begin
        if (cal_cnt != 32'd0) begin
          elapsed = ev.us_counter - base_us;
          whole_s = elapsed / US_PER_SEC;
          frac_us = elapsed % US_PER_SEC;
          r.seconds      = whole_s[31:0] + (cal_on ? epoch_target : epoch_prev);
          r.microseconds = frac_us[19:0];
        end
      end
      default: ;
    endcase
    r.time_valid = (cal_cnt != 32'd0);
    r.delay_ms   = delay_last;
    r.sync_phase = sync_state;
    r.calibrated = cal_on;
    return r;
  endfunction

  function automatic in_item_t make_event(input logic [2:0] m, input logic [31:0] ms,
                                          input logic [63:0] us, input logic [31:0] utc);
    in_item_t ev;
    ev.mode        = m;
    ev.ms_tick     = ms;
    ev.us_counter  = us;
    ev.utc_seconds = utc;
    return ev;
  endfunction

  function automatic dir_row_t mk_row(input logic [2:0] m, input logic [31:0] ms,
                                      input logic [63:0] us, input logic [31:0] utc,
                                      input bit clear);
    dir_row_t row;
    row.ev           = make_event(m, ms, us, utc);
    row.clear_status = clear;
    return row;
  endfunction

  task automatic check_status(input out_item_t exp, input out_item_t act);
    if (act.time_valid !== exp.time_valid) begin
      $error("time_valid: expected %0d, got %0d", exp.time_valid, act.time_valid);
      fail_cnt++;
    end
    if (act.seconds !== exp.seconds) begin
      $error("seconds: expected %0d, got %0d", exp.seconds, act.seconds);
      fail_cnt++;
    end
    if (act.microseconds !== exp.microseconds) begin
      $error("microseconds: expected %0d, got %0d", exp.microseconds, act.microseconds);
      fail_cnt++;
    end
    if (act.delay_ms !== exp.delay_ms) begin
      $error("delay_ms: expected %0d, got %0d", exp.delay_ms, act.delay_ms);
      fail_cnt++;
    end
    if (act.sync_phase !== exp.sync_phase) begin
      $error("sync_phase: expected %0d, got %0d", exp.sync_phase, act.sync_phase);
      fail_cnt++;
    end
    if (act.calibrated !== exp.calibrated) begin
      $error("calibrated: expected %0d, got %0d", exp.calibrated, act.calibrated);
      fail_cnt++;
    end
  endtask

  // request and result handshakes, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        status_now = step_calibration(in_item);
        if (in_typed) status_q.push_back(STATUS_CLEAR);
        else status_q.push_back(status_now);
      end
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          $error("result returned with no request outstanding");
          fail_cnt++;
        end else begin
          check_status(status_q.pop_front(), out_item);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= (idle_sel == IDLE_LIGHT_SEND ? 59 :
                                            idle_sel == IDLE_HEAVY_SEND ? 35 : 0));
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_event(input in_item_t ev, input bit typed);
    int gap_pct;
    gap_pct = (idle_sel == IDLE_LIGHT_SEND) ? 35 : (idle_sel == IDLE_HEAVY_SEND) ? 59 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = ev;
    in_typed = typed;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    events_sent++;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] value);
    logic [31:0] want;
    want   = (sel == REG_STABLE) ? {24'd0, value[7:0]} : value;
    paddr  = {sel, 2'b00};
    pwdata = value;
    pwrite = 1'b1;
    psel   = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    if (sel == REG_STABLE) cfg_stable = value[7:0];
    else cfg_interval = value;
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("prdata: expected %0d, got %0d", want, prdata);
      fail_cnt++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // one second of receiver traffic, sometimes broken or padded with noise
  task automatic send_second();
    int k;
    int n;
    if ($urandom_range(0, 99) < 2) tick_now = $urandom;
    else tick_now = tick_now + $urandom_range(990, 1010);
    usc_now = usc_now + $urandom_range(999000, 1001000);
    utc_now = ($urandom_range(0, 99) < 3) ? $urandom : utc_now + 32'd1;

    if ($urandom_range(0, 99) < 10) begin
      // lost messages: a run of bare pulses
      n = $urandom_range(5, 20);
      for (k = 0; k < n; k++) begin
        send_event(make_event(MODE_PPS, tick_now, usc_now, $urandom), 1'b0);
        tick_now = tick_now + $urandom_range(990, 1010);
        usc_now  = usc_now + $urandom_range(999000, 1001000);
      end
    end
    if ($urandom_range(0, 99) < 92)
      send_event(make_event(MODE_PPS, tick_now, usc_now, $urandom), 1'b0);
    if ($urandom_range(0, 99) < 85)
      send_event(make_event(MODE_MSG, tick_now + $urandom_range(0, 400),
                            {$urandom, $urandom}, $urandom), 1'b0);
    if ($urandom_range(0, 99) < 85)
      send_event(make_event(MODE_UTC, tick_now + $urandom_range(400, 600),
                            {$urandom, $urandom},
                            ($urandom_range(0, 99) < 8) ? utc_now - 32'd1 : utc_now), 1'b0);
    n = $urandom_range(0, 2);
    for (k = 0; k < n; k++)
      send_event(make_event(MODE_CHECK,
                            ($urandom_range(0, 99) < 5) ? tick_now + $urandom
                                                        : tick_now + $urandom_range(0, 999),
                            {$urandom, $urandom}, $urandom), 1'b0);
    n = $urandom_range(0, 2);
    for (k = 0; k < n; k++)
      send_event(make_event(MODE_QUERY, tick_now + $urandom_range(0, 999),
                            ($urandom_range(0, 99) < 5) ? {$urandom, $urandom}
                                                        : usc_now + $urandom_range(0, 1200000),
                            $urandom), 1'b0);
    if ($urandom_range(0, 99) < 20) begin
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++)
        send_event(make_event(3'($urandom_range(0, 7)), $urandom, {$urandom, $urandom},
                              $urandom), 1'b0);
    end
  endtask

  task automatic run_phase(input logic [7:0] stable, input logic [31:0] interval,
                           input idle_mode_t mode_sel);
    int start;
    wait_drained();
    write_reg(REG_STABLE, {24'd0, stable});
    write_reg(REG_RECAL, interval);
    idle_sel = mode_sel;
    start = events_sent;
    while (events_sent - start < ITEMS_PER_PHASE) send_second();
  endtask

  initial begin
    int i;
    tick_now = $urandom;
    usc_now  = {$urandom, $urandom};
    utc_now  = $urandom;

    // rows flagged clear expect the all-zero status of an uncalibrated block
    dir_rows.push_back(mk_row(MODE_QUERY, 32'd0, ALL64, ALL32, 1'b1));
    dir_rows.push_back(mk_row(MODE_RSVD_C, ALL32, ALL64, ALL32, 1'b1));
    dir_rows.push_back(mk_row(MODE_RSVD_A, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                              32'h5555_5555, 1'b1));
    dir_rows.push_back(mk_row(MODE_RSVD_B, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555,
                              32'hAAAA_AAAA, 1'b1));
    dir_rows.push_back(mk_row(MODE_CHECK, ALL32, 64'd0, 32'd0, 1'b1));
    dir_rows.push_back(mk_row(MODE_MSG, 32'd123, 64'd0, 32'd0, 1'b1));
    dir_rows.push_back(mk_row(MODE_UTC, 32'd456, 64'd0, 32'd1000, 1'b1));
    for (i = 1; i <= 4; i++)
      dir_rows.push_back(mk_row(MODE_PPS, 32'(i * 1000), 64'(i * 1000000), 32'd0, 1'b1));
    // fifth pulse starts the delay measurement
    dir_rows.push_back(mk_row(MODE_PPS, 32'd5000, 64'd5000000, 32'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_MSG, 32'd4000, 64'd0, 32'd0, 1'b0));
    // UTC+1 wraps to zero, equal to the old target: nothing armed
    dir_rows.push_back(mk_row(MODE_UTC, 32'd4100, 64'd0, ALL32, 1'b0));
    dir_rows.push_back(mk_row(MODE_PPS, 32'd6000, 64'd6000000, 32'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_MSG, 32'd6150, 64'd0, 32'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_UTC, 32'd6200, 64'd0, 32'hFFFF_FFFE, 1'b0));
    // latch at tick zero, near the top of the microsecond counter
    dir_rows.push_back(mk_row(MODE_PPS, 32'd0, 64'hFFFF_FFFF_FFF0_0000, 32'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_QUERY, 32'd50, 64'h0000_0000_0010_0000, 32'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_CHECK, ALL32, 64'd0, 32'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_MSG, 32'd20, 64'd0, 32'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_QUERY, 32'd60, 64'hFFFF_FFFF_FFFF_423F, 32'd0, 1'b0));
    dir_rows.push_back(mk_row(MODE_UTC, 32'd70, 64'd0, 32'd12345, 1'b0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    idle_sel = IDLE_LIGHT_SEND;
    foreach (dir_rows[j]) send_event(dir_rows[j].ev, dir_rows[j].clear_status);

    run_phase(8'd0, 32'd0, IDLE_LIGHT_SEND);
    run_phase(8'd255, ALL32, IDLE_HEAVY_SEND);
    run_phase(8'd1, 32'd1, IDLE_NONE);
    run_phase(8'($urandom_range(0, 8)), $urandom_range(500, 5000), IDLE_LIGHT_SEND);
    run_phase(8'd2, 32'd60000, IDLE_HEAVY_SEND);
    run_phase(8'($urandom_range(0, 15)), $urandom_range(1, 3000), IDLE_NONE);
    wait_drained();

    if (fail_cnt == 0 && status_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> pps_time_sync_calibrator_top.f
rtl/core/ptsc_pkg.sv
rtl/core/pps_time_sync_calibrator_top.sv
tb/tb_pps_time_sync_calibrator_top.sv
